>>> hw/rtl/hc3i_pkg.sv
// ---------------------------------------------------------------------------
// hc3i_pkg
// Shared constants and types for the 3D Hilbert-style curve index core.
// ---------------------------------------------------------------------------
package hc3i_pkg;

	// Default number of curve levels, one pipeline stage each
	localparam int LEVELS_DEF = 14;

	// Default fraction bits of the input coordinates (Q1.F)
	localparam int COORD_FRAC_BITS_DEF = 23;

	// x/y quadrant of a point, named by the sign of x then y
	typedef enum logic [1:0] {
		QUAD_XPOS_YPOS = 2'b00,
		QUAD_XPOS_YNEG = 2'b01,
		QUAD_XNEG_YPOS = 2'b10,
		QUAD_XNEG_YNEG = 2'b11
	} quad_t;

endpackage

>>> hw/rtl/hc3i_point_if.sv
// ---------------------------------------------------------------------------
// hc3i_point_if
// Valid/ready channel that carries one point request (x, y, z coordinates).
// ---------------------------------------------------------------------------
interface hc3i_point_if #(
	parameter int COORD_FRAC_BITS = hc3i_pkg::COORD_FRAC_BITS_DEF
);
	localparam int CW = COORD_FRAC_BITS + 1;

	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] coord_x;
	logic signed [CW-1:0] coord_y;
	logic signed [CW-1:0] coord_z;

	modport source (output valid, output coord_x, output coord_y, output coord_z,
		input ready);
	modport sink (input valid, input coord_x, input coord_y, input coord_z,
		output ready);
endinterface

>>> hw/rtl/hc3i_pos_if.sv
// ---------------------------------------------------------------------------
// hc3i_pos_if
// Valid/ready channel that carries one curve position request.
// ---------------------------------------------------------------------------
interface hc3i_pos_if #(
	parameter int LEVELS = hc3i_pkg::LEVELS_DEF
);
	localparam int PW = 3 * LEVELS + 1;

	logic          valid;
	logic          ready;
	logic [PW-1:0] curve_position;

	modport source (output valid, output curve_position, input ready);
	modport sink (input valid, input curve_position, output ready);
endinterface

>>> hw/rtl/hilbert_curve_3d_index_core.sv
// Each accepted point passes through the stage registers of every level before its position is valid.
// Throughput: one point per cycle while the output is not stalled; each curve level is one pipeline stage.
// A stalled output freezes the whole pipeline, which then accepts nothing.
// Reset: arst_n clears all stage valid bits asynchronously; data regs unreset.
// ---------------------------------------------------------------------------
// hilbert_curve_3d_index_core
// Pipelined key generator: maps a point of [-1,1)^3 to its position along
// a fixed 3D Hilbert-style curve in units of 8^-LEVELS.
// ---------------------------------------------------------------------------
module hilbert_curve_3d_index_core #(
	parameter int LEVELS          = hc3i_pkg::LEVELS_DEF,
	parameter int COORD_FRAC_BITS = hc3i_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hc3i_point_if.sink  point,
	hc3i_pos_if.source  position
);
	localparam int CW = COORD_FRAC_BITS + 1;   // input coordinate width
	localparam int W  = COORD_FRAC_BITS + 2;   // internal width with guard bit
	localparam int OW = 3 * LEVELS + 1;        // position width

	localparam logic signed [W:0]  ONE_EXT = (W+1)'(1) << COORD_FRAC_BITS;
	localparam logic signed [W-1:0] ONE_C  = W'(1) << COORD_FRAC_BITS;
	localparam logic [OW-1:0]       TOP    = OW'(1) << (3 * LEVELS);

	// Pipeline state, one entry per level
	logic                 vld_s [LEVELS];
	logic signed [W-1:0]  x_s   [LEVELS];
	logic signed [W-1:0]  y_s   [LEVELS];
	logic signed [W-1:0]  z_s   [LEVELS];
	logic        [OW-1:0] sum_s [LEVELS];
	logic                 neg_s [LEVELS];

	logic stall;

	// Re-center: c >= 0 -> 2c-1, c < 0 -> 2c+1 (exact, stays in [-1,1])
	function automatic logic signed [W-1:0] recenter(input logic signed [W-1:0] v);
		logic signed [W:0] dbl;
		logic signed [W:0] res;
		dbl = {v, 1'b0};
		res = v[W-1] ? (dbl + ONE_EXT) : (dbl - ONE_EXT);
		return res[W-1:0];
	endfunction

	// Global stall: a held result freezes every stage
	assign stall       = vld_s[LEVELS-1] && !position.ready;
	assign point.ready = !stall;

	assign position.valid          = vld_s[LEVELS-1];
	assign position.curve_position = sum_s[LEVELS-1];

	for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
		localparam int SH = 3 * (LEVELS - lv);
		localparam logic [OW-1:0] SIZE = OW'(1) << SH;
		localparam logic [OW-1:0] STEP = OW'(1) << (SH - 3);

		logic                 vi;
		logic signed [W-1:0]  xi, yi, zi;
		logic        [OW-1:0] si;
		logic                 ni;
		logic                 zpos;
		logic signed [W-1:0]  zm;
		logic        [OW-1:0] sum1;
		logic                 neg1;
		logic signed [W-1:0]  a, b, c;
		hc3i_pkg::quad_t      quad;
		logic        [OW-1:0] add;
		logic signed [W-1:0]  xn, yn, zn;
		logic        [OW-1:0] sum2;

		// Stage inputs: the port for the first level, the prior stage otherwise
		if (lv == 0) begin : g_first
			assign vi = point.valid;
			assign xi = {point.coord_x[CW-1], point.coord_x};
			assign yi = {point.coord_y[CW-1], point.coord_y};
			assign zi = {point.coord_z[CW-1], point.coord_z};
			assign si = '0;
			assign ni = 1'b0;
		end else begin : g_next
			assign vi = vld_s[lv-1];
			assign xi = x_s[lv-1];
			assign yi = y_s[lv-1];
			assign zi = z_s[lv-1];
			assign si = sum_s[lv-1];
			assign ni = neg_s[lv-1];
		end

		// z mirror: add level size with running sign, then flip the sign
		always_comb begin
			zpos = !zi[W-1] && (zi != '0);
			zm   = zpos ? -zi : zi;
			sum1 = zpos ? (ni ? si - SIZE : si + SIZE) : si;
			neg1 = ni ^ zpos;
		end

		// Quadrant step and the three fixed axis rotations
		always_comb begin
			a    = recenter(xi);
			b    = recenter(yi);
			c    = recenter(zm);
			quad = hc3i_pkg::quad_t'({xi[W-1], yi[W-1]});
			case (quad)
				hc3i_pkg::QUAD_XPOS_YPOS: begin
					add = '0;
					xn = -c; yn = a; zn = -b;
				end
				hc3i_pkg::QUAD_XPOS_YNEG: begin
					add = STEP;
					xn = b; yn = -c; zn = -a;
				end
				hc3i_pkg::QUAD_XNEG_YNEG: begin
					add = STEP << 1;
					xn = b; yn = -c; zn = -a;
				end
				hc3i_pkg::QUAD_XNEG_YPOS: begin
					add = (STEP << 1) + STEP;
					xn = -a; yn = -b; zn = c;
				end
				default: begin
					add = '0;
					xn = -c; yn = a; zn = -b;
				end
			endcase
			sum2 = neg1 ? sum1 - add : sum1 + add;
		end

		// Stage valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[lv] <= 1'b0;
			end else if (!stall) begin
				vld_s[lv] <= vi;
			end
		end

		// Stage data
		always_ff @(posedge clk) begin
			if (!stall) begin
				x_s[lv]   <= xn;
				y_s[lv]   <= yn;
				z_s[lv]   <= zn;
				sum_s[lv] <= sum2;
				neg_s[lv] <= neg1;
			end
		end
	end

`ifndef SYNTHESIS
	// Final position never exceeds the top of the curve
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		position.valid |-> (position.curve_position <= TOP))
		else $error("curve position above 8^LEVELS");

	// Guard bit: coordinates of the last stage stay within [-1,1]
	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LEVELS-1] |-> ((x_s[LEVELS-1] <= ONE_C) && (x_s[LEVELS-1] >= -ONE_C) &&
			(y_s[LEVELS-1] <= ONE_C) && (y_s[LEVELS-1] >= -ONE_C) &&
			(z_s[LEVELS-1] <= ONE_C) && (z_s[LEVELS-1] >= -ONE_C)))
		else $error("coordinate left [-1,1]");

	// A stall freezes the first stage valid bit
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(vld_s[0]))
		else $error("pipeline moved during stall");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for hilbert_curve_3d_index_core. Point requests are
// driven with random gaps and the position output is stalled at random. Each
// accepted point is run through a level-by-level curve walk here, and the
// position that comes out is compared in order against that prediction.
// ---------------------------------------------------------------------------
module tb;
	localparam int LEVELS     = hc3i_pkg::LEVELS_DEF;
	localparam int FRAC       = hc3i_pkg::COORD_FRAC_BITS_DEF;
	localparam int CW         = FRAC + 1;
	localparam int PW         = 3 * LEVELS + 1;
	localparam int NUM_RANDOM = 2000;

	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam longint               COORD_ONE = longint'(1) << FRAC;

	typedef logic signed [CW-1:0] coord_t;
	// two bits of headroom: guard bit for +1.0 plus room for the doubling
	typedef logic signed [CW+1:0] walk_t;
	typedef logic [PW-1:0]        pos_t;

	// Expected curve positions, kept in request order
	class curve_scoreboard;
		pos_t        expected_q[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		static function walk_t recentre(walk_t c);
			return (c >= 0) ? walk_t'(2 * longint'(c) - COORD_ONE)
				: walk_t'(2 * longint'(c) + COORD_ONE);
		endfunction

		// Walk the curve one level at a time, as the pipeline does
		static function pos_t predict_position(coord_t cx, coord_t cy, coord_t cz);
			walk_t           x, y, z, a, b, c;
			bit [63:0]       sum, size, step, add;
			bit              flip;
			hc3i_pkg::quad_t quad;
			x = walk_t'(cx);
			y = walk_t'(cy);
			z = walk_t'(cz);
			sum = '0;
			flip = 1'b0;
			for (int lv = 0; lv < LEVELS; lv++) begin
				size = 64'd1 << (3 * (LEVELS - lv));
				step = size >> 3;
				// upper half in z: mirror and flip the running sign
				if (z > 0) begin
					sum = flip ? sum - size : sum + size;
					flip = !flip;
					z = -z;
				end
				a = recentre(x);
				b = recentre(y);
				c = recentre(z);
				quad = hc3i_pkg::quad_t'({x < 0, y < 0});
				case (quad)
					hc3i_pkg::QUAD_XPOS_YPOS: begin
						add = 64'd0;
						x = -c; y = a; z = -b;
					end
					hc3i_pkg::QUAD_XPOS_YNEG: begin
						add = step;
						x = b; y = -c; z = -a;
					end
					hc3i_pkg::QUAD_XNEG_YNEG: begin
						add = 2 * step;
						x = b; y = -c; z = -a;
					end
					default: begin
						add = 3 * step;
						x = -a; y = -b; z = c;
					end
				endcase
				sum = flip ? sum - add : sum + add;
			end
			return sum[PW-1:0];
		endfunction

		function void note_point(coord_t x, coord_t y, coord_t z);
			expected_q = {expected_q, predict_position(x, y, z)};
		endfunction

		function void check_position(pos_t got);
			pos_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("position %h arrived with no request pending", got);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("position mismatch: expected %h, got %h", want, got);
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	curve_scoreboard sb;
	bit              src_quiet;
	bit              snk_quiet;

	hc3i_point_if #(.COORD_FRAC_BITS(FRAC)) point_ch();
	hc3i_pos_if #(.LEVELS(LEVELS))          pos_ch();

	hilbert_curve_3d_index_core #(
		.LEVELS(LEVELS),
		.COORD_FRAC_BITS(FRAC)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.point(point_ch),
		.position(pos_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the pipeline hangs
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int unsigned draw_wait(bit quiet);
		return quiet ? 0 : $urandom_range(0, 9);
	endfunction

	// Mix of edge values, small magnitudes and full-range noise
	function automatic coord_t draw_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return '0;
			3: return coord_t'(int'($urandom_range(0, 3)) - 2);
			4: return coord_t'(int'($urandom_range(0, 4095)) - 2048);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Issue one point request, with a random gap ahead of it
	task automatic send_point(coord_t x, coord_t y, coord_t z);
		int unsigned gap;
		gap = draw_wait(src_quiet);
		if (gap != 0) begin
			point_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_ch.valid   <= 1'b1;
		point_ch.coord_x <= x;
		point_ch.coord_y <= y;
		point_ch.coord_z <= z;
		do @(posedge clk); while (!point_ch.ready);
	endtask

	// Monitors sample pre-edge values at every rising edge
	always @(posedge clk) begin
		if (arst_n && point_ch.valid && point_ch.ready)
			sb.note_point(point_ch.coord_x, point_ch.coord_y, point_ch.coord_z);
		if (arst_n && pos_ch.valid && pos_ch.ready)
			sb.check_position(pos_ch.curve_position);
	end

	// Output side: random stall before each result, quiet stretches now and then
	initial begin : position_sink
		int unsigned stall;
		int unsigned left_in_mode;
		pos_ch.ready = 1'b0;
		snk_quiet = 1'b0;
		left_in_mode = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (left_in_mode == 0) begin
				snk_quiet = ($urandom_range(0, 3) == 0);
				left_in_mode = $urandom_range(30, 150);
			end
			left_in_mode--;
			stall = draw_wait(snk_quiet);
			if (stall != 0) begin
				pos_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pos_ch.ready <= 1'b1;
			do @(posedge clk); while (!pos_ch.valid);
		end
	end

	initial begin : point_source
		int unsigned left_in_mode;
		sb = new();
		arst_n = 1'b0;
		point_ch.valid = 1'b0;
		point_ch.coord_x = '0;
		point_ch.coord_y = '0;
		point_ch.coord_z = '0;
		src_quiet = 1'b0;
		left_in_mode = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every octant at the far corners
		for (int k = 0; k < 8; k++)
			send_point(k[0] ? COORD_MIN : COORD_MAX, k[1] ? COORD_MIN : COORD_MAX,
				k[2] ? COORD_MIN : COORD_MAX);
		// zero counts as positive; z at zero is not mirrored
		send_point('0, '0, '0);
		send_point('0, '0, COORD_MAX);
		send_point('0, '0, COORD_MIN);
		send_point(COORD_MIN, '0, '0);
		send_point('0, COORD_MIN, '0);
		send_point(COORD_MAX, COORD_MAX, '0);
		send_point('0, '0, coord_t'(1));
		send_point(coord_t'(1), coord_t'(1), coord_t'(1));
		send_point(-coord_t'(1), -coord_t'(1), -coord_t'(1));
		send_point(-coord_t'(1), coord_t'(1), '0);
		send_point(coord_t'(1), -coord_t'(1), coord_t'(1));
		send_point(COORD_MIN, COORD_MAX, coord_t'(1));
		send_point(COORD_MAX, COORD_MIN, -coord_t'(1));

		// random points, with bursts of back-to-back requests
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (left_in_mode == 0) begin
				src_quiet = ($urandom_range(0, 3) == 0);
				left_in_mode = $urandom_range(30, 150);
			end
			left_in_mode--;
			send_point(draw_coord(), draw_coord(), draw_coord());
		end
		point_ch.valid <= 1'b0;

		// drain, then let the pipeline settle
		while (sb.pending() != 0) @(posedge clk);
		repeat (LEVELS + 8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
